[sv/dts_pkg.sv]
// types, constants and transition tables for the dfa token scanner
package dts_pkg;

  localparam longint MaxTokenLength = 65535;
  localparam int     NumStates      = 9;
  localparam int     NumClasses     = 7;

  // result queue depth, a power of two
  localparam int     QDepth         = 4;
  localparam int     QPtrW          = $clog2(QDepth);

  localparam logic [15:0] LenLimit =
    (MaxTokenLength > 65535) ? 16'hFFFF :
    (MaxTokenLength < 1)     ? 16'd1    : 16'(MaxTokenLength);

  typedef logic [3:0] scan_state_t;

  typedef logic [QPtrW-1:0] q_ptr_t;
  typedef logic [QPtrW:0]   q_cnt_t;

  localparam scan_state_t StartState = 4'd0;
  localparam scan_state_t NoMove     = 4'hF;

  typedef enum logic [2:0] {
    KIND_INCOMPLETE = 3'd0,
    KIND_NUMBER     = 3'd1,
    KIND_WHITESPACE = 3'd2,
    KIND_IDENT      = 3'd3,
    KIND_ERROR      = 3'd4,
    KIND_UNMATCHED  = 3'd5
  } token_kind_t;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_EE    = 3'd1,
    CLS_DOT   = 3'd2,
    CLS_AT    = 3'd3,
    CLS_BLANK = 3'd4,
    CLS_UNDER = 3'd5,
    CLS_ALPHA = 3'd6,
    CLS_NONE  = 3'd7
  } char_class_t;

  typedef struct packed {
    char_class_t first;
    char_class_t second;
  } class_pair_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [15:0] token_length;
    logic        final_token;
  } token_t;

  localparam scan_state_t NextState [0:NumClasses-1][0:NumStates-1] = '{
    '{4'd1,   4'd1,   4'd2,   4'd2,   4'd5,   4'd5,   NoMove, 4'd7,   NoMove},
    '{NoMove, 4'd4,   4'd4,   NoMove, NoMove, NoMove, NoMove, NoMove, NoMove},
    '{4'd3,   4'd2,   NoMove, NoMove, NoMove, NoMove, NoMove, NoMove, NoMove},
    '{4'd8,   NoMove, NoMove, NoMove, NoMove, NoMove, NoMove, NoMove, NoMove},
    '{4'd6,   NoMove, NoMove, NoMove, NoMove, NoMove, 4'd6,   NoMove, NoMove},
    '{4'd7,   NoMove, NoMove, NoMove, NoMove, NoMove, NoMove, 4'd7,   NoMove},
    '{4'd7,   NoMove, NoMove, NoMove, NoMove, NoMove, NoMove, 4'd7,   NoMove}
  };

  localparam token_kind_t AcceptKind [0:NumStates-1] = '{
    KIND_INCOMPLETE, KIND_NUMBER, KIND_NUMBER, KIND_INCOMPLETE, KIND_INCOMPLETE,
    KIND_NUMBER, KIND_WHITESPACE, KIND_IDENT, KIND_ERROR
  };

  function automatic class_pair_t classes_of(logic [7:0] c);
    class_pair_t p;
    p.first  = CLS_NONE;
    p.second = CLS_NONE;
    if (c >= 8'h61 && c <= 8'h7A) begin
      p.first = CLS_ALPHA;
      if (c == 8'h65) begin
        p.second = CLS_EE;
      end
    end else if (c >= 8'h30 && c <= 8'h39) begin
      p.first = CLS_DIGIT;
    end else if (c == 8'h45) begin
      p.first = CLS_EE;
    end else if (c == 8'h20 || c == 8'h0A || c == 8'h09 || c == 8'h08) begin
      p.first = CLS_BLANK;
    end else if (c == 8'h2E) begin
      p.first = CLS_DOT;
    end else if (c == 8'h40) begin
      p.first = CLS_AT;
    end else if (c == 8'h5F) begin
      p.first = CLS_UNDER;
    end
    return p;
  endfunction

  function automatic scan_state_t move_on(scan_state_t st, logic [7:0] c);
    class_pair_t p;
    scan_state_t n;
    p = classes_of(c);
    n = NoMove;
    if (st < 4'(NumStates)) begin
      if (p.first != CLS_NONE) begin
        n = NextState[p.first][st];
      end
      if (n == NoMove && p.second != CLS_NONE) begin
        n = NextState[p.second][st];
      end
    end
    return n;
  endfunction

  function automatic token_kind_t kind_of(scan_state_t st);
    token_kind_t k;
    k = KIND_INCOMPLETE;
    if (st < 4'(NumStates)) begin
      k = AcceptKind[st];
    end
    return k;
  endfunction

endpackage

[sv/dts_in_if.sv]
// character input channel
interface dts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

[sv/dts_out_if.sv]
// token result channel
interface dts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_length;
  logic        final_token;

  modport source (output valid, output token_kind, output token_length,
                  output final_token, input ready);
  modport sink   (input valid, input token_kind, input token_length,
                  input final_token, output ready);
endinterface

[sv/dfa_token_scanner.sv]
// maximal-munch dfa token scanner, one character per transfer
// path: an accepted character waits in the staging register until two queue slots are
//   free, then its tokens are written to the result queue, whose head drives the output
// throughput: one character per cycle; a character that ends two tokens needs two
//   output transfers, and the input holds off while fewer than two queue slots are free
// reset: synchronous, active low; clears the scan state, run length and queue
module dfa_token_scanner (
  input  logic          clk,
  input  logic          rst_n,
  dts_in_if.sink        in_ch,
  dts_out_if.source     out_ch
);
  import dts_pkg::*;

  logic        stg_v_r, stg_v_nxt;
  logic [7:0]  stg_char_r;
  logic        stg_eot_r;

  scan_state_t scan_state_r, scan_state_nxt;
  logic [15:0] run_length_r, run_length_nxt;

  token_t      q_mem_r [QDepth];
  q_ptr_t      wp_r, wp_nxt;
  q_ptr_t      rp_r, rp_nxt;
  q_cnt_t      cnt_r, cnt_nxt;

  logic        in_xfer;
  logic        out_xfer;
  logic        drain;

  token_t      tok0, tok1;
  logic [1:0]  n_emit;
  scan_state_t st_c;
  logic [15:0] len_c;

  assign drain        = stg_v_r && (cnt_r <= q_cnt_t'(QDepth - 2));
  assign in_ch.ready  = !stg_v_r || drain;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = (cnt_r != q_cnt_t'(0));
  assign out_ch.token_kind   = q_mem_r[rp_r].token_kind;
  assign out_ch.token_length = q_mem_r[rp_r].token_length;
  assign out_ch.final_token  = q_mem_r[rp_r].final_token;
  assign out_xfer            = out_ch.valid && out_ch.ready;

  // token step for the staged character
  always_comb begin
    scan_state_t mv;
    token_t      t;
    st_c   = scan_state_r;
    len_c  = run_length_r;
    n_emit = 2'd0;
    tok0   = '0;
    tok1   = '0;
    mv     = NoMove;
    t      = '0;
    if (st_c != StartState) begin
      mv = move_on(st_c, stg_char_r);
      if (mv != NoMove) begin
        st_c  = mv;
        len_c = (len_c >= LenLimit) ? len_c : len_c + 16'd1;
      end else begin
        tok0   = '{token_kind: kind_of(st_c), token_length: len_c, final_token: 1'b0};
        n_emit = 2'd1;
        st_c   = StartState;
        len_c  = 16'd0;
      end
    end
    if (st_c == StartState) begin
      mv = move_on(StartState, stg_char_r);
      if (mv == NoMove) begin
        t = '{token_kind: KIND_UNMATCHED, token_length: 16'd1, final_token: 1'b0};
        if (n_emit == 2'd0) begin
          tok0 = t;
        end else begin
          tok1 = t;
        end
        n_emit = n_emit + 2'd1;
      end else begin
        st_c  = mv;
        len_c = 16'd1;
      end
    end
    if (stg_eot_r) begin
      if (st_c != StartState) begin
        t = '{token_kind: kind_of(st_c), token_length: len_c, final_token: 1'b0};
        if (n_emit == 2'd0) begin
          tok0 = t;
        end else begin
          tok1 = t;
        end
        n_emit = n_emit + 2'd1;
        st_c   = StartState;
        len_c  = 16'd0;
      end
      if (n_emit == 2'd1) begin
        tok0.final_token = 1'b1;
      end else if (n_emit == 2'd2) begin
        tok1.final_token = 1'b1;
      end
    end
  end

  always_comb begin
    stg_v_nxt      = in_xfer ? 1'b1 : (drain ? 1'b0 : stg_v_r);
    scan_state_nxt = drain ? st_c : scan_state_r;
    run_length_nxt = drain ? len_c : run_length_r;
    wp_nxt         = drain ? wp_r + q_ptr_t'(n_emit) : wp_r;
    rp_nxt         = out_xfer ? rp_r + q_ptr_t'(1) : rp_r;
    cnt_nxt        = cnt_r + (drain ? q_cnt_t'(n_emit) : q_cnt_t'(0)) - q_cnt_t'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r      <= 1'b0;
      scan_state_r <= StartState;
      run_length_r <= 16'd0;
      wp_r         <= '0;
      rp_r         <= '0;
      cnt_r        <= '0;
    end else begin
      stg_v_r      <= stg_v_nxt;
      scan_state_r <= scan_state_nxt;
      run_length_r <= run_length_nxt;
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_char_r <= in_ch.char_code;
      stg_eot_r  <= in_ch.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && n_emit != 2'd0) begin
      q_mem_r[wp_r] <= tok0;
    end
    if (drain && n_emit == 2'd2) begin
      q_mem_r[wp_r + q_ptr_t'(1)] <= tok1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= q_cnt_t'(QDepth))
    else $error("result queue over its depth");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    drain |-> (int'(cnt_r) + int'(n_emit)) <= QDepth)
    else $error("tokens pushed without room");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_state_r < 4'(NumStates))
    else $error("scan state out of range");

  a_len_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_state_r == StartState) == (run_length_r == 16'd0))
    else $error("run length disagrees with pending token");

  a_eot_flush: assert property (@(posedge clk) disable iff (!rst_n)
    drain && stg_eot_r |=> scan_state_r == StartState)
    else $error("token left pending after end of text");
`endif

endmodule

[test/dts_token_checker.sv]
// token predictor and scoreboard for the dfa token scanner
`timescale 1ns / 100ps
module dts_token_checker (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     final_check,
  dts_in_if        in_ch,
  dts_out_if       out_ch,
  output int       fail_count,
  output int       pending_tokens,
  output int       tokens_checked,
  output bit [7:0] kinds_seen
);
  import dts_pkg::*;

  localparam scan_state_t ST_INT     = 4'd1;
  localparam scan_state_t ST_FRAC    = 4'd2;
  localparam scan_state_t ST_DOT     = 4'd3;
  localparam scan_state_t ST_EXP     = 4'd4;
  localparam scan_state_t ST_EXP_DIG = 4'd5;
  localparam scan_state_t ST_BLANK   = 4'd6;
  localparam scan_state_t ST_IDENT   = 4'd7;
  localparam scan_state_t ST_AT      = 4'd8;

  localparam int MaxPrinted = 40;

  token_t      expected_tokens[$];
  scan_state_t scan_st;
  logic [15:0] run_len;
  bit          leftovers_reported;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MaxPrinted) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic scan_state_t dfa_next(scan_state_t s, logic [7:0] c);
    bit          lower;
    bit          digit;
    bit          blank;
    bit          is_e;
    scan_state_t n;
    lower = (c >= "a") && (c <= "z");
    digit = (c >= "0") && (c <= "9");
    blank = (c == 8'h20) || (c == 8'h0A) || (c == 8'h09) || (c == 8'h08);
    is_e  = (c == "e") || (c == "E");
    n = NoMove;
    case (s)
      StartState: begin
        if (digit) n = ST_INT;
        else if (lower || c == "_") n = ST_IDENT;
        else if (c == ".") n = ST_DOT;
        else if (c == "@") n = ST_AT;
        else if (blank) n = ST_BLANK;
      end
      ST_INT: begin
        if (digit) n = ST_INT;
        else if (is_e) n = ST_EXP;
        else if (c == ".") n = ST_FRAC;
      end
      ST_FRAC: begin
        if (digit) n = ST_FRAC;
        else if (is_e) n = ST_EXP;
      end
      ST_DOT: begin
        if (digit) n = ST_FRAC;
      end
      ST_EXP, ST_EXP_DIG: begin
        if (digit) n = ST_EXP_DIG;
      end
      ST_BLANK: begin
        if (blank) n = ST_BLANK;
      end
      ST_IDENT: begin
        if (digit || lower || c == "_") n = ST_IDENT;
      end
      default: n = NoMove;
    endcase
    return n;
  endfunction

  function automatic token_kind_t kind_for(scan_state_t s);
    case (s)
      ST_INT, ST_FRAC, ST_EXP_DIG: return KIND_NUMBER;
      ST_BLANK:                    return KIND_WHITESPACE;
      ST_IDENT:                    return KIND_IDENT;
      ST_AT:                       return KIND_ERROR;
      default:                     return KIND_INCOMPLETE;
    endcase
  endfunction

  task automatic push_token(input token_kind_t kind, input logic [15:0] len);
    token_t t;
    t.token_kind   = kind;
    t.token_length = len;
    t.final_token  = 1'b0;
    expected_tokens = {expected_tokens, t};
  endtask

  task automatic predict_char(input logic [7:0] c, input logic eot);
    scan_state_t nx;
    int          made;
    made = 0;
    if (scan_st != StartState) begin
      nx = dfa_next(scan_st, c);
      if (nx != NoMove) begin
        scan_st = nx;
        if (run_len < LenLimit) run_len++;
      end else begin
        push_token(kind_for(scan_st), run_len);
        made++;
        scan_st = StartState;
        run_len = '0;
      end
    end
    if (scan_st == StartState) begin
      nx = dfa_next(StartState, c);
      if (nx == NoMove) begin
        push_token(KIND_UNMATCHED, 16'd1);
        made++;
      end else begin
        scan_st = nx;
        run_len = 16'd1;
      end
    end
    if (eot) begin
      if (scan_st != StartState) begin
        push_token(kind_for(scan_st), run_len);
        made++;
        scan_st = StartState;
        run_len = '0;
      end
      if (made > 0) expected_tokens[expected_tokens.size() - 1].final_token = 1'b1;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    token_t want;
    if (!rst_n) begin
      expected_tokens.delete();
      scan_st = StartState;
      run_len = '0;
      fail_count = 0;
      tokens_checked = 0;
      kinds_seen = '0;
      leftovers_reported = 1'b0;
      pending_tokens <= 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        tokens_checked++;
        if (!$isunknown(out_ch.token_kind)) kinds_seen[out_ch.token_kind] = 1'b1;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("token kind %0d length %0d with nothing expected",
                                    out_ch.token_kind, out_ch.token_length));
        end else begin
          want = expected_tokens.pop_front();
          if (out_ch.token_kind !== want.token_kind)
            report_mismatch($sformatf("token %0d kind %0d, expected %0d", tokens_checked,
                                      out_ch.token_kind, want.token_kind));
          if (out_ch.token_length !== want.token_length)
            report_mismatch($sformatf("token %0d length %0d, expected %0d", tokens_checked,
                                      out_ch.token_length, want.token_length));
          if (out_ch.final_token !== want.final_token)
            report_mismatch($sformatf("token %0d final flag %b, expected %b", tokens_checked,
                                      out_ch.final_token, want.final_token));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        predict_char(in_ch.char_code, in_ch.end_of_text);
      end
      if (final_check && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        foreach (expected_tokens[i]) begin
          report_mismatch($sformatf("token kind %0d length %0d never came",
                                    expected_tokens[i].token_kind,
                                    expected_tokens[i].token_length));
        end
        expected_tokens.delete();
      end
      pending_tokens <= expected_tokens.size();
    end
  end

endmodule

[test/tb_dfa_token_scanner.sv]
// top of the dfa token scanner testbench: clock, reset, character stimulus and verdict
`timescale 1ns / 100ps
module tb_dfa_token_scanner;

  localparam int RandomChars  = 1500;
  localparam int IdleLimit    = 2000;
  localparam int SettleCycles = 20;

  localparam logic [8:0] DirectedText [25] = '{
    {1'b0, 8'h00}, {1'b1, 8'hFF}, {1'b0, "1"},   {1'b0, "."},   {1'b0, "5"},
    {1'b0, "e"},   {1'b0, "7"},   {1'b0, "E"},   {1'b0, 8'h20}, {1'b0, 8'h09},
    {1'b0, 8'h0A}, {1'b0, 8'h08}, {1'b0, "a"},   {1'b0, "e"},   {1'b0, "_"},
    {1'b0, "z"},   {1'b0, "9"},   {1'b0, "@"},   {1'b0, "@"},   {1'b1, "."},
    {1'b0, "1"},   {1'b1, "e"},   {1'b1, "x"},   {1'b0, "3"},   {1'b1, "#"}
  };

  logic     clk;
  logic     rst_n;
  logic     final_check;
  int       fail_count;
  int       pending_tokens;
  int       tokens_checked;
  bit [7:0] kinds_seen;

  bit          idle_on;
  int          chars_sent;
  int          texts_ended;
  int          idle_cycles;
  logic [7:0]  lexeme[$];

  dts_in_if  in_ch ();
  dts_out_if out_ch ();

  dfa_token_scanner u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dts_token_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .final_check    (final_check),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens),
    .tokens_checked (tokens_checked),
    .kinds_seen     (kinds_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(48, 57));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return 8'h20;
      1:       return 8'h0A;
      2:       return 8'h09;
      default: return 8'h08;
    endcase
  endfunction

  function automatic logic [7:0] rand_ident_char();
    int r;
    r = $urandom_range(0, 37);
    if (r < 26) return 8'($urandom_range(97, 122));
    if (r < 36) return rand_digit();
    return "_";
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= c;
    in_ch.end_of_text <= eot;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    chars_sent++;
    if (eot) texts_ended++;
  endtask

  // hold the input off until every predicted token has been seen
  task automatic drain_input();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_tokens != 0);
  endtask

  task automatic add_char(input logic [7:0] c);
    lexeme = {lexeme, c};
  endtask

  // mostly well-formed lexemes, with broken numbers and raw bytes mixed in
  task automatic make_lexeme();
    int pick;
    int n;
    lexeme.delete();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      n = $urandom_range(1, 4);
      repeat (n) add_char(rand_digit());
      if ($urandom_range(0, 9) < 4) begin
        add_char(".");
        repeat ($urandom_range(0, 3)) add_char(rand_digit());
      end
      if ($urandom_range(0, 9) < 3) begin
        add_char($urandom_range(0, 1) ? 8'h65 : 8'h45);
        repeat ($urandom_range(0, 2)) add_char(rand_digit());
      end
    end else if (pick < 45) begin
      add_char($urandom_range(0, 4) == 0 ? 8'h5F : 8'($urandom_range(97, 122)));
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 6);
      repeat (n) add_char(rand_ident_char());
    end else if (pick < 60) begin
      repeat ($urandom_range(1, 4)) add_char(rand_blank());
    end else if (pick < 68) begin
      repeat ($urandom_range(1, 3)) add_char("@");
    end else if (pick < 75) begin
      add_char(".");
      repeat ($urandom_range(0, 3)) add_char(rand_digit());
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0:       add_char(8'h65);
          1:       add_char(8'h45);
          default: add_char(rand_digit());
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_lexeme();
    bit end_text;
    bit eot;
    end_text = ($urandom_range(0, 19) == 0);
    foreach (lexeme[i]) begin
      eot = (end_text && i == lexeme.size() - 1) || ($urandom_range(0, 149) == 0);
      send_char(lexeme[i], eot);
    end
  endtask

  initial begin : stimulus
    int  start;
    bit  paused;
    rst_n              <= 1'b0;
    final_check        <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.char_code    <= '0;
    in_ch.end_of_text  <= 1'b0;
    idle_on     = 1'b1;
    chars_sent  = 0;
    texts_ended = 0;
    paused      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedText[i]) send_char(DirectedText[i][7:0], DirectedText[i][8]);
    drain_input();

    start = chars_sent;
    while (chars_sent - start < RandomChars) begin
      if ($urandom_range(0, 29) == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (!paused && chars_sent - start >= RandomChars / 2) begin
        drain_input();
        paused = 1'b1;
      end
      make_lexeme();
      send_lexeme();
    end
    in_ch.valid <= 1'b0;

    while (pending_tokens != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    final_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("covered %0d characters in %0d ended texts, with stalls on both sides",
             chars_sent, texts_ended);
    $display("compared %0d tokens, token kinds seen %b", tokens_checked, kinds_seen[5:0]);
    if (fail_count == 0) begin
      $display("tb_dfa_token_scanner OK");
    end else begin
      $display("tb_dfa_token_scanner NOT OK");
    end
    $finish;
  end

  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("stuck: no transfer for %0d cycles, %0d tokens outstanding",
               idle_cycles, pending_tokens);
      $display("tb_dfa_token_scanner NOT OK");
      $finish;
    end
  end

endmodule
